### sv/gcb_pkg.sv
`timescale 1ns / 1ps
// gcb_pkg: shared types, angle constants and CORDIC table functions for the
// great-circle bearing block. No dependencies.
package gcb_pkg;

   localparam int ANG_W = 40;         // signed nanodegree angle width
   localparam int N_W   = 39;         // dividend width for the output scaling
   localparam int Q_W   = 22;         // bearing width, 1e-4 degree units
   localparam int LANES = 3;          // start lat, destination lat, delta lon

   typedef logic signed [ANG_W-1:0] ang_type;

   typedef struct packed {
      logic valid;
      logic zero;                     // force bearing to zero
   } ctl_type;

   localparam ang_type FULL_TURN    = 40'sd360000000000;
   localparam ang_type HALF_TURN    = 40'sd180000000000;
   localparam ang_type QUARTER_TURN = 40'sd90000000000;
   localparam ang_type NDEG_PER_IN  = 40'sd100;

   localparam logic [N_W-1:0] OUT_HALF = 39'd50000;
   localparam logic [Q_W-1:0] OUT_TURN = 22'd3600000;

   // divide by 100000 = 2^5 * 3125: shift by 5, then multiply by
   // ceil(2^45 / 3125); exact for every 34-bit numerator
   localparam int DIV_SHIFT   = 5;
   localparam int R_W         = 34;
   localparam int RECIP_SHIFT = 45;
   localparam logic [R_W-1:0] RECIP_3125 = 34'd11258999069;

   localparam logic [63:0] RADIAN_NDEG = 64'd57295779513;
   localparam logic [63:0] KINV_NUM    = 64'd607252935008881256;
   localparam logic [63:0] KINV_DEN    = 64'd1000000000000000000;

   localparam int ATAN_TAB_LEN = 14;
   localparam logic [63:0] ATAN_TAB [ATAN_TAB_LEN] = '{
      64'd45000000000, 64'd26565051177, 64'd14036243468, 64'd7125016349,
      64'd3576334375,  64'd1789910608,  64'd895173710,   64'd447614171,
      64'd223810500,   64'd111905677,   64'd55952892,    64'd27976453,
      64'd13988227,    64'd6994114
   };

   // atan(2^-i) in nanodegrees
   function automatic ang_type atan_step(input int unsigned i);
      logic [63:0] v;
      if (i < ATAN_TAB_LEN) begin
         v = ATAN_TAB[i[3:0]];
      end else begin
         v = (RADIAN_NDEG + (64'd1 << (i - 1))) >> i;
      end
      return ang_type'(v);
   endfunction

   // round(1/K * 2^frac), restoring long division of the decimal constant
   function automatic logic [63:0] kinv_fix(input int unsigned frac);
      logic [63:0] r;
      logic [63:0] q;
      r = KINV_NUM;
      q = '0;
      for (int unsigned k = 0; k <= frac; k++) begin
         r = r << 1;
         q = q << 1;
         if (r >= KINV_DEN) begin
            r = r - KINV_DEN;
            q[0] = 1'b1;
         end
      end
      return (q + 64'd1) >> 1;
   endfunction

endpackage

### sv/gcb_sincos.sv
`timescale 1ns / 1ps
// gcb_sincos: three-lane pipelined rotation CORDIC, sine and cosine of
// nanodegree angles. Depends on gcb_pkg.
module gcb_sincos #(
   parameter int STEPS = 24,
   parameter int FRAC  = 30
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  gcb_pkg::ctl_type   in_ctl,
   input  gcb_pkg::ang_type   in_ang [gcb_pkg::LANES],
   output gcb_pkg::ctl_type   out_ctl,
   output logic signed [FRAC+2:0] out_sin [gcb_pkg::LANES],
   output logic signed [FRAC+2:0] out_cos [gcb_pkg::LANES]
);
   import gcb_pkg::*;

   localparam int XW = FRAC + 3;
   localparam logic signed [XW-1:0] X_START = XW'(kinv_fix(FRAC));

   ctl_type                ctl_ff [STEPS+1];
   ctl_type                out_ctl_ff;
   logic signed [XW-1:0]   x_ff   [LANES][STEPS+1];
   logic signed [XW-1:0]   y_ff   [LANES][STEPS+1];
   ang_type                z_ff   [LANES][STEPS];
   logic                   neg_ff [LANES][STEPS+1];
   logic signed [XW-1:0]   sin_ff [LANES];
   logic signed [XW-1:0]   cos_ff [LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0] <= '0;
      end else if (en) begin
         ctl_ff[0] <= in_ctl;
      end
   end

   for (genvar k = 1; k <= STEPS; k++) begin : g_ctl
      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k] <= '0;
         end else if (en) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ctl_ff <= '0;
      end else if (en) begin
         out_ctl_ff <= ctl_ff[STEPS];
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      ang_type fold_in;
      logic    fneg_in;

      // fold into +-90 degrees, flip the result sign afterwards
      assign fneg_in = (in_ang[l] > QUARTER_TURN) || (in_ang[l] < -QUARTER_TURN);
      assign fold_in = (in_ang[l] > QUARTER_TURN)  ? in_ang[l] - HALF_TURN :
                       (in_ang[l] < -QUARTER_TURN) ? in_ang[l] + HALF_TURN :
                                                     in_ang[l];

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[l][0]   <= X_START;
            y_ff[l][0]   <= '0;
            z_ff[l][0]   <= fold_in;
            neg_ff[l][0] <= fneg_in;
         end
      end

      for (genvar k = 1; k <= STEPS; k++) begin : g_step
         logic signed [XW-1:0] x_in;
         logic signed [XW-1:0] y_in;
         logic                 dir;

         assign dir  = !z_ff[l][k-1][ANG_W-1];
         assign x_in = dir ? x_ff[l][k-1] - (y_ff[l][k-1] >>> (k-1))
                           : x_ff[l][k-1] + (y_ff[l][k-1] >>> (k-1));
         assign y_in = dir ? y_ff[l][k-1] + (x_ff[l][k-1] >>> (k-1))
                           : y_ff[l][k-1] - (x_ff[l][k-1] >>> (k-1));

         always_ff @(posedge clock) begin
            if (en) begin
               x_ff[l][k]   <= x_in;
               y_ff[l][k]   <= y_in;
               neg_ff[l][k] <= neg_ff[l][k-1];
            end
         end

         if (k < STEPS) begin : g_z
            localparam ang_type ATAN_K = atan_step(k - 1);
            ang_type z_in;
            assign z_in = dir ? z_ff[l][k-1] - ATAN_K : z_ff[l][k-1] + ATAN_K;
            always_ff @(posedge clock) begin
               if (en) begin
                  z_ff[l][k] <= z_in;
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sin_ff[l] <= neg_ff[l][STEPS] ? -y_ff[l][STEPS] : y_ff[l][STEPS];
            cos_ff[l] <= neg_ff[l][STEPS] ? -x_ff[l][STEPS] : x_ff[l][STEPS];
         end
      end
   end

   assign out_ctl = out_ctl_ff;
   assign out_sin = sin_ff;
   assign out_cos = cos_ff;

endmodule

### sv/gcb_atan.sv
`timescale 1ns / 1ps
// gcb_atan: pipelined vectoring CORDIC, angle of (north, east) clockwise from
// north in nanodegrees. Depends on gcb_pkg.
module gcb_atan #(
   parameter int STEPS = 24,
   parameter int FRAC  = 30
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  gcb_pkg::ctl_type       in_ctl,
   input  logic signed [FRAC+2:0] in_north,
   input  logic signed [FRAC+2:0] in_east,
   output gcb_pkg::ctl_type       out_ctl,
   output gcb_pkg::ang_type       out_z
);
   import gcb_pkg::*;

   localparam int VW = FRAC + 4;      // headroom for the CORDIC gain

   ctl_type              ctl_ff [STEPS+1];
   logic signed [VW-1:0] a_ff   [STEPS];
   logic signed [VW-1:0] b_ff   [STEPS];
   ang_type              z_ff   [STEPS+1];

   logic signed [VW-1:0] ne;
   logic signed [VW-1:0] ee;
   logic signed [VW-1:0] a0_in;
   logic signed [VW-1:0] b0_in;
   ang_type              z0_in;

   assign ne = VW'(in_north);
   assign ee = VW'(in_east);

   // left half-plane: turn by 180 degrees first
   assign a0_in = ne[VW-1] ? -ne : ne;
   assign b0_in = ne[VW-1] ? -ee : ee;
   assign z0_in = !ne[VW-1] ? '0 : (ee[VW-1] ? -HALF_TURN : HALF_TURN);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0] <= '0;
      end else if (en) begin
         ctl_ff[0] <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff[0] <= a0_in;
         b_ff[0] <= b0_in;
         z_ff[0] <= z0_in;
      end
   end

   for (genvar k = 1; k <= STEPS; k++) begin : g_step
      localparam ang_type ATAN_K = atan_step(k - 1);
      ang_type z_in;
      logic    dir;

      assign dir  = !b_ff[k-1][VW-1];
      assign z_in = dir ? z_ff[k-1] + ATAN_K : z_ff[k-1] - ATAN_K;

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k] <= '0;
         end else if (en) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            z_ff[k] <= z_in;
         end
      end

      if (k < STEPS) begin : g_ab
         logic signed [VW-1:0] a_in;
         logic signed [VW-1:0] b_in;
         assign a_in = dir ? a_ff[k-1] + (b_ff[k-1] >>> (k-1))
                           : a_ff[k-1] - (b_ff[k-1] >>> (k-1));
         assign b_in = dir ? b_ff[k-1] - (a_ff[k-1] >>> (k-1))
                           : b_ff[k-1] + (a_ff[k-1] >>> (k-1));
         always_ff @(posedge clock) begin
            if (en) begin
               a_ff[k] <= a_in;
               b_ff[k] <= b_in;
            end
         end
      end
   end

   assign out_ctl = ctl_ff[STEPS];
   assign out_z   = z_ff[STEPS];

endmodule

### sv/great_circle_bearing.sv
`timescale 1ns / 1ps
// great_circle_bearing: initial great-circle bearing between two positions.
// Depends on gcb_pkg, gcb_sincos and gcb_atan.
//
// Usage:
//   Request channel (req_): start and destination latitude/longitude in
//   1e-7 degree units. An item is taken at a clock edge with req_valid high
//   and req_stall low. Response channel (rsp_): bearing clockwise from north
//   in 1e-4 degree units, 0..3599999, one result per item, in order.
//   Throughput: one item per cycle while the output is not stalled. The
//   pipeline is a single chain of registers sized by the two CORDIC units:
//   input scaling and longitude wrap, sine/cosine CORDIC, products and
//   rounding, atan2 CORDIC, angle wrap, output scaling by a split
//   reciprocal multiply and the output register.
//   When the output holds an item and rsp_stall is high, the whole pipeline
//   freezes and req_stall is raised; nothing is dropped or repeated.
//   Synchronous reset clears all valid bits; data registers are not reset.
//   Identical points and a zero direction vector give bearing 0.
module great_circle_bearing #(
   parameter int CORDIC_STEPS = 24,
   parameter int FRAC_BITS    = 30
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [30:0] req_from_lat,
   input  logic signed [31:0] req_from_lon,
   input  logic signed [30:0] req_to_lat,
   input  logic signed [31:0] req_to_lon,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [21:0]        rsp_bearing
);
   import gcb_pkg::*;

   localparam int XW = FRAC_BITS + 3;  // sine/cosine and product width
   localparam int PW = 2 * XW;         // full product width
   localparam int HW = R_W / 2;        // numerator half width
   localparam int PPW = R_W + HW;      // partial product width
   localparam int SW = 2 * R_W;        // full reciprocal product width

   // product rounded to FRAC_BITS, ties away from zero
   function automatic logic signed [XW-1:0] fround(input logic signed [PW-1:0] p);
      logic [PW-1:0] mag;
      logic [PW-1:0] m;
      mag = p[PW-1] ? $unsigned(-p) : $unsigned(p);
      m   = (mag + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      return p[PW-1] ? XW'(-m) : XW'(m);
   endfunction

   logic en;                           // global advance

   logic rsp_valid_ff;
   logic [Q_W-1:0] rsp_bearing_ff;

   // whole pipeline moves unless a finished item is held at the output
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   // ---- stage 0: scale to nanodegrees, longitude difference
   logic    v0_ff;
   ang_type slat0_ff, dlat0_ff, dlon0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         slat0_ff <= ang_type'(req_from_lat) * NDEG_PER_IN;
         dlat0_ff <= ang_type'(req_to_lat) * NDEG_PER_IN;
         dlon0_ff <= (ang_type'(req_to_lon) - ang_type'(req_from_lon)) * NDEG_PER_IN;
      end
   end

   // ---- stage 1: wrap delta longitude into [-180, 180), same-point check
   ang_type dl1_in;
   ctl_type ctl1_in, ctl1_ff;
   ang_type slat1_ff, dlat1_ff, dl1_ff;

   // the difference stays inside +-1.2 turns, so one correction is enough
   assign dl1_in = (dlon0_ff >= HALF_TURN)  ? dlon0_ff - FULL_TURN :
                   (dlon0_ff < -HALF_TURN)  ? dlon0_ff + FULL_TURN :
                                              dlon0_ff;
   assign ctl1_in.valid = v0_ff;
   assign ctl1_in.zero  = (slat0_ff == dlat0_ff) && (dl1_in == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
      end else if (en) begin
         ctl1_ff <= ctl1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         slat1_ff <= slat0_ff;
         dlat1_ff <= dlat0_ff;
         dl1_ff   <= dl1_in;
      end
   end

   // ---- sine and cosine of the three angles
   ang_type              sc_ang [LANES];
   logic signed [XW-1:0] sc_sin [LANES];
   logic signed [XW-1:0] sc_cos [LANES];
   ctl_type              sc_ctl;

   assign sc_ang[0] = slat1_ff;
   assign sc_ang[1] = dlat1_ff;
   assign sc_ang[2] = dl1_ff;

   gcb_sincos #(
      .STEPS (CORDIC_STEPS),
      .FRAC  (FRAC_BITS)
   ) u_sincos (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_ctl  (ctl1_ff),
      .in_ang  (sc_ang),
      .out_ctl (sc_ctl),
      .out_sin (sc_sin),
      .out_cos (sc_cos)
   );

   // ---- M1: cos(slat)sin(dlat), sin(slat)cos(dlat), cos(dlat)sin(dl)
   ctl_type              m1_ctl_ff;
   logic signed [PW-1:0] pa1_ff, pb1_ff, pc1_ff;
   logic signed [XW-1:0] cdl1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_ctl_ff <= '0;
      end else if (en) begin
         m1_ctl_ff <= sc_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pa1_ff  <= PW'(sc_cos[0]) * PW'(sc_sin[1]);
         pb1_ff  <= PW'(sc_sin[0]) * PW'(sc_cos[1]);
         pc1_ff  <= PW'(sc_cos[1]) * PW'(sc_sin[2]);
         cdl1_ff <= sc_cos[2];
      end
   end

   // ---- M2: round
   ctl_type              m2_ctl_ff;
   logic signed [XW-1:0] ra2_ff, rb2_ff, east2_ff, cdl2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_ctl_ff <= '0;
      end else if (en) begin
         m2_ctl_ff <= m1_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ra2_ff   <= fround(pa1_ff);
         rb2_ff   <= fround(pb1_ff);
         east2_ff <= fround(pc1_ff);
         cdl2_ff  <= cdl1_ff;
      end
   end

   // ---- M3: times cos(dl)
   ctl_type              m3_ctl_ff;
   logic signed [PW-1:0] pd3_ff;
   logic signed [XW-1:0] ra3_ff, east3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m3_ctl_ff <= '0;
      end else if (en) begin
         m3_ctl_ff <= m2_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pd3_ff   <= PW'(rb2_ff) * PW'(cdl2_ff);
         ra3_ff   <= ra2_ff;
         east3_ff <= east2_ff;
      end
   end

   // ---- M4: round
   ctl_type              m4_ctl_ff;
   logic signed [XW-1:0] rd4_ff, ra4_ff, east4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m4_ctl_ff <= '0;
      end else if (en) begin
         m4_ctl_ff <= m3_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rd4_ff   <= fround(pd3_ff);
         ra4_ff   <= ra3_ff;
         east4_ff <= east3_ff;
      end
   end

   // ---- M5: north term, zero-vector check
   ctl_type              m5_ctl_in, m5_ctl_ff;
   logic signed [XW-1:0] north5_ff, east5_ff;

   assign m5_ctl_in.valid = m4_ctl_ff.valid;
   assign m5_ctl_in.zero  = m4_ctl_ff.zero || ((east4_ff == '0) && (ra4_ff == rd4_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         m5_ctl_ff <= '0;
      end else if (en) begin
         m5_ctl_ff <= m5_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         north5_ff <= ra4_ff - rd4_ff;
         east5_ff  <= east4_ff;
      end
   end

   // ---- atan2(east, north)
   ctl_type at_ctl;
   ang_type at_z;

   gcb_atan #(
      .STEPS (CORDIC_STEPS),
      .FRAC  (FRAC_BITS)
   ) u_atan (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_ctl   (m5_ctl_ff),
      .in_north (north5_ff),
      .in_east  (east5_ff),
      .out_ctl  (at_ctl),
      .out_z    (at_z)
   );

   // ---- W1: wrap into [0, 360) and add half an output step
   ang_type        zw_in;
   ctl_type        w_ctl_ff;
   logic [N_W-1:0] num_ff;

   assign zw_in = at_z[ANG_W-1]       ? at_z + FULL_TURN :
                  (at_z >= FULL_TURN) ? at_z - FULL_TURN :
                                        at_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ctl_ff <= '0;
      end else if (en) begin
         w_ctl_ff <= at_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff <= N_W'(zw_in) + OUT_HALF;
      end
   end

   // ---- D1: drop the factor 2^5, multiply both numerator halves by 1/3125
   logic [R_W-1:0] dm;
   ctl_type        d1_ctl_ff;
   logic [PPW-1:0] phi1_ff, plo1_ff;

   assign dm = num_ff[N_W-1:DIV_SHIFT];

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_ctl_ff <= '0;
      end else if (en) begin
         d1_ctl_ff <= w_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         phi1_ff <= PPW'(dm[R_W-1:HW]) * PPW'(RECIP_3125);
         plo1_ff <= PPW'(dm[HW-1:0]) * PPW'(RECIP_3125);
      end
   end

   // ---- D2: combine the halves, keep the quotient bits
   logic [SW-1:0]  sum2_in;
   ctl_type        d2_ctl_ff;
   logic [Q_W-1:0] q2_ff;

   assign sum2_in = {phi1_ff, {HW{1'b0}}} + SW'(plo1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         d2_ctl_ff <= '0;
      end else if (en) begin
         d2_ctl_ff <= d1_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q2_ff <= sum2_in[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];
      end
   end

   // ---- output register; a full turn after rounding reads as 0
   logic [Q_W-1:0] bearing_in;

   assign bearing_in = (d2_ctl_ff.zero || (q2_ff == OUT_TURN)) ? '0 : q2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= d2_ctl_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_bearing_ff <= bearing_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_bearing = rsp_bearing_ff;

endmodule

### sv/gcb_checker.sv
`timescale 1ns / 1ps
// gcb_checker: port-level assertions for great_circle_bearing, attached by
// bind. Depends on nothing else.
module gcb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [21:0] rsp_bearing
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_bearing))
      else $error("stalled response changed");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_bearing < 22'd3600000)
      else $error("bearing out of range");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("request stall not tied to a blocked response");

endmodule

bind great_circle_bearing gcb_checker u_gcb_checker (.*);
